[rtl/core/cfp_pkg.sv]
package cfp_pkg;

    localparam int CW       = 32;            // Q16.16 coordinate
    localparam int DFW      = CW + 1;        // vertex minus plane point
    localparam int PW       = DFW + CW;      // one term of the dot product
    localparam int SW       = 67;            // plane distance, Q35.32
    localparam int DW       = SW + 1;        // distance difference
    localparam int SPLIT_LO = 34;            // low part of a distance operand
    localparam int LW       = CW + SPLIT_LO + 1;
    localparam int HW       = CW + SW - SPLIT_LO;
    localparam int NW       = 100;           // intercept numerator
    localparam int QB       = 33;            // quotient bits before rounding

    localparam int DIST_LAT  = 3;
    localparam int ISECT_LAT = 4;
    localparam int DIV_LAT   = QB + 3;
    localparam int PIPE_LAT  = 1 + DIST_LAT + 1 + ISECT_LAT + DIV_LAT;
    localparam int SB_LEN    = ISECT_LAT + DIV_LAT + 1;

    localparam logic [2:0] TYPE_NONE = 3'd0;
    localparam logic [2:0] TYPE_PATH = 3'd1;
    localparam logic [2:0] TYPE_LINE = 3'd2;
    localparam logic [2:0] TYPE_TRI  = 3'd3;

    localparam logic [2:0] REG_PT_X   = 3'd0;
    localparam logic [2:0] REG_PT_Y   = 3'd1;
    localparam logic [2:0] REG_PT_Z   = 3'd2;
    localparam logic [2:0] REG_NRM_X  = 3'd3;
    localparam logic [2:0] REG_NRM_Y  = 3'd4;
    localparam logic [2:0] REG_NRM_Z  = 3'd5;
    localparam logic [2:0] REG_MARGIN = 3'd6;

    localparam logic [QB:0]   POS_LIM = 34'h0_7FFF_FFFF;
    localparam logic [QB:0]   NEG_LIM = 34'h0_8000_0000;
    localparam logic [CW-1:0] SAT_HI  = 32'h7FFF_FFFF;
    localparam logic [CW-1:0] SAT_LO  = 32'h8000_0000;

    typedef logic signed [CW-1:0] coord_t;
    typedef coord_t [2:0] vtx_t;
    typedef vtx_t [2:0] tri_t;

    typedef enum logic [2:0] {
        SRC_A,
        SRC_B,
        SRC_C,
        SRC_I0,
        SRC_I1
    } src_t;

    typedef struct packed {
        logic [2:0] ftype;
        tri_t       pts;
    } frag_t;

    typedef struct packed {
        logic [2:0]     ftype;
        logic           split;
        src_t [2:0]     sel0;
        src_t [2:0]     sel1;
        tri_t           pts;
    } side_t;

    typedef struct packed {
        vtx_t          p;
        vtx_t          q;
        logic [SW-1:0] sp;
        logic [SW-1:0] sq;
    } slot_t;

    function automatic logic [1:0] nxt3(logic [1:0] i);
        return (i == 2'd2) ? 2'd0 : i + 2'd1;
    endfunction

    function automatic src_t pt_src(logic [1:0] i);
        src_t r;
        case (i)
            2'd0: r = SRC_A;
            2'd1: r = SRC_B;
            default: r = SRC_C;
        endcase
        return r;
    endfunction

endpackage

[rtl/core/cfp_dist.sv]
module cfp_dist (
    input  logic                  aclk,
    input  logic                  en,
    input  cfp_pkg::vtx_t         pt,
    input  cfp_pkg::vtx_t         plane_pt,
    input  cfp_pkg::vtx_t         nrm,
    input  logic [15:0]           margin,
    output logic [cfp_pkg::SW-1:0] s,
    output logic                  bad
);
    import cfp_pkg::*;

    logic [2:0][DFW-1:0] d_reg, d_next;
    logic [2:0][PW-1:0]  m_reg, m_next;
    logic [SW-1:0]       s_reg, s_next;
    logic                bad_reg, bad_next;

    always_comb begin
        logic signed [DFW-1:0] da;
        logic signed [CW-1:0]  nb;
        logic signed [PW-1:0]  pr;
        logic signed [SW-1:0]  acc;
        logic signed [SW-1:0]  thr;
        for (int k = 0; k < 3; k++) begin
            d_next[k] = DFW'($signed(pt[k])) - DFW'($signed(plane_pt[k]));
            da = $signed(d_reg[k]);
            nb = $signed(nrm[k]);
            pr = da * nb;
            m_next[k] = pr;
        end
        acc = $signed(m_reg[0]) + $signed(m_reg[1]) + $signed(m_reg[2]);
        thr = -$signed({{(SW-32){1'b0}}, margin, 16'b0});
        s_next = acc;
        bad_next = acc < thr;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg   <= d_next;
            m_reg   <= m_next;
            s_reg   <= s_next;
            bad_reg <= bad_next;
        end
    end

    assign s   = s_reg;
    assign bad = bad_reg;

endmodule

[rtl/core/cfp_isect.sv]
module cfp_isect (
    input  logic                              aclk,
    input  logic                              en,
    input  cfp_pkg::slot_t                    slot,
    output logic [2:0][cfp_pkg::NW-1:0]       an,
    output logic [cfp_pkg::DW-1:0]            ad,
    output logic [2:0]                        neg
);
    import cfp_pkg::*;

    logic [2:0][LW-1:0] pl_reg, pl_next, ql_reg, ql_next;
    logic [2:0][HW-1:0] ph_reg, ph_next, qh_reg, qh_next;
    logic [2:0][NW-1:0] a_reg, a_next, b_reg, b_next;
    logic [2:0][NW-1:0] n_reg, n_next;
    logic [2:0][NW-1:0] an_reg, an_next;
    logic [2:0]         neg_reg, neg_next;
    logic [DW-1:0]      den1_reg, den1_next, den2_reg, den3_reg;
    logic [DW-1:0]      ad_reg, ad_next;

    // numerator p*sq - q*sp, split on the wide operand
    always_comb begin
        logic signed [SPLIT_LO:0]      sq_l, sp_l;
        logic signed [SW-SPLIT_LO-1:0] sq_h, sp_h;
        logic signed [CW-1:0]          pc, qc;
        logic signed [LW-1:0]          t_l;
        logic signed [HW-1:0]          t_h;
        logic signed [NW-1:0]          t_a, t_b, t_n;
        sq_l = {1'b0, slot.sq[SPLIT_LO-1:0]};
        sp_l = {1'b0, slot.sp[SPLIT_LO-1:0]};
        sq_h = slot.sq[SW-1:SPLIT_LO];
        sp_h = slot.sp[SW-1:SPLIT_LO];
        for (int k = 0; k < 3; k++) begin
            pc = slot.p[k];
            qc = slot.q[k];
            t_l = pc * sq_l;
            pl_next[k] = t_l;
            t_h = pc * sq_h;
            ph_next[k] = t_h;
            t_l = qc * sp_l;
            ql_next[k] = t_l;
            t_h = qc * sp_h;
            qh_next[k] = t_h;
            t_a = $signed({ph_reg[k], {SPLIT_LO{1'b0}}}) + $signed(pl_reg[k]);
            a_next[k] = t_a;
            t_b = $signed({qh_reg[k], {SPLIT_LO{1'b0}}}) + $signed(ql_reg[k]);
            b_next[k] = t_b;
            t_n = $signed(a_reg[k]) - $signed(b_reg[k]);
            n_next[k] = t_n;
            an_next[k] = n_reg[k][NW-1] ? -n_reg[k] : n_reg[k];
            neg_next[k] = n_reg[k][NW-1] ^ den3_reg[DW-1];
        end
        den1_next = DW'($signed(slot.sq)) - DW'($signed(slot.sp));
        ad_next = den3_reg[DW-1] ? -den3_reg : den3_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pl_reg   <= pl_next;
            ph_reg   <= ph_next;
            ql_reg   <= ql_next;
            qh_reg   <= qh_next;
            den1_reg <= den1_next;
            a_reg    <= a_next;
            b_reg    <= b_next;
            den2_reg <= den1_reg;
            n_reg    <= n_next;
            den3_reg <= den2_reg;
            an_reg   <= an_next;
            neg_reg  <= neg_next;
            ad_reg   <= ad_next;
        end
    end

    assign an  = an_reg;
    assign ad  = ad_reg;
    assign neg = neg_reg;

endmodule

[rtl/core/cfp_div.sv]
module cfp_div (
    input  logic                  aclk,
    input  logic                  en,
    input  logic [cfp_pkg::NW-1:0] num,
    input  logic [cfp_pkg::DW-1:0] den,
    input  logic                  neg,
    output cfp_pkg::coord_t        res
);
    import cfp_pkg::*;

    logic [NW-1:0] r_reg  [QB+1];
    logic [DW-1:0] d_reg  [QB+1];
    logic [QB-1:0] q_reg  [QB+1];
    logic          ng_reg [QB+1];
    logic          ov_reg [QB+1];

    logic [QB:0]   qr_reg, qr_next;
    logic          ngr_reg, ovr_reg;
    logic [CW-1:0] res_reg, res_next;

    // quotient past 33 bits saturates anyway
    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg[0]  <= num;
            d_reg[0]  <= den;
            q_reg[0]  <= '0;
            ng_reg[0] <= neg;
            ov_reg[0] <= {1'b0, num} >= {den, {QB{1'b0}}};
        end
    end

    for (genvar j = 0; j < QB; j++) begin : g_step
        localparam int B = QB - 1 - j;
        logic [NW:0] trial;
        logic        ge;
        assign trial = {{(NW+1-DW){1'b0}}, d_reg[j]} << B;
        assign ge    = {1'b0, r_reg[j]} >= trial;
        always_ff @(posedge aclk) begin
            if (en) begin
                r_reg[j+1]  <= ge ? r_reg[j] - trial[NW-1:0] : r_reg[j];
                q_reg[j+1]  <= {q_reg[j][QB-2:0], ge};
                d_reg[j+1]  <= d_reg[j];
                ng_reg[j+1] <= ng_reg[j];
                ov_reg[j+1] <= ov_reg[j];
            end
        end
    end

    always_comb begin
        logic          rnd;
        logic [QB:0]   nq;
        rnd = {r_reg[QB][DW-1:0], 1'b0} >= {1'b0, d_reg[QB]};
        qr_next = {1'b0, q_reg[QB]} + (QB+1)'(rnd);
        nq = -qr_reg;
        if (!ngr_reg) begin
            res_next = (ovr_reg || qr_reg > POS_LIM) ? SAT_HI : qr_reg[CW-1:0];
        end else begin
            res_next = (ovr_reg || qr_reg > NEG_LIM) ? SAT_LO : nq[CW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            qr_reg  <= qr_next;
            ngr_reg <= ng_reg[QB];
            ovr_reg <= ov_reg[QB];
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

[rtl/core/clip_fragment_against_plane.sv]
// channel   direction  handshake            payload
// s_        in         s_valid / s_ready    s_fragment_type, s_a_x .. s_c_z
// m_        out        m_valid / m_ready    m_out_type, m_out_a_x .. m_out_c_z, m_last_of_run
// cfg_      in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// One request per cycle unless m_ready stalls the output or a split is pending;
// the intercept coordinates are formed by the 33-step restoring divider.
// A triangle split into two holds the whole pipeline until its second output is taken.
// Synchronous active-low reset clears valid bits and the plane registers.
// m_ready low while a result is waiting freezes every stage; nothing is dropped or replayed.
module clip_fragment_against_plane (
    input  logic             aclk,
    input  logic             aresetn,

    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [2:0]       cfg_index,
    input  logic [31:0]      cfg_data,

    input  logic             s_valid,
    output logic             s_ready,
    input  logic [2:0]       s_fragment_type,
    input  cfp_pkg::coord_t  s_a_x,
    input  cfp_pkg::coord_t  s_a_y,
    input  cfp_pkg::coord_t  s_a_z,
    input  cfp_pkg::coord_t  s_b_x,
    input  cfp_pkg::coord_t  s_b_y,
    input  cfp_pkg::coord_t  s_b_z,
    input  cfp_pkg::coord_t  s_c_x,
    input  cfp_pkg::coord_t  s_c_y,
    input  cfp_pkg::coord_t  s_c_z,

    output logic             m_valid,
    input  logic             m_ready,
    output logic [2:0]       m_out_type,
    output cfp_pkg::coord_t  m_out_a_x,
    output cfp_pkg::coord_t  m_out_a_y,
    output cfp_pkg::coord_t  m_out_a_z,
    output cfp_pkg::coord_t  m_out_b_x,
    output cfp_pkg::coord_t  m_out_b_y,
    output cfp_pkg::coord_t  m_out_b_z,
    output cfp_pkg::coord_t  m_out_c_x,
    output cfp_pkg::coord_t  m_out_c_y,
    output cfp_pkg::coord_t  m_out_c_z,
    output logic             m_last_of_run
);
    import cfp_pkg::*;

    logic          en;
    vtx_t          ppt_reg, nrm_reg;
    logic [15:0]   margin_reg;

    logic [PIPE_LAT-1:0] v_reg;
    frag_t         in_reg, in_next;
    frag_t         sa_reg [DIST_LAT];
    logic [2:0][SW-1:0] s_w;
    logic [2:0]    bad_w;

    side_t         side_next;
    slot_t         slot_next [2];
    side_t         sb_reg [SB_LEN];
    slot_t         slot_reg [2];

    logic [2:0][NW-1:0] an_w [2];
    logic [DW-1:0] ad_w [2];
    logic [2:0]    neg_w [2];
    vtx_t          ires [2];

    logic          e_valid_reg, e_phase_reg, e_split_reg;
    logic [2:0]    e_type_reg;
    tri_t          e_r0_reg, e_r1_reg, r0_next, r1_next, cur_tri;
    side_t         sb_out;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ppt_reg    <= '0;
            nrm_reg    <= '0;
            margin_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_PT_X:   ppt_reg[0] <= cfg_data;
                REG_PT_Y:   ppt_reg[1] <= cfg_data;
                REG_PT_Z:   ppt_reg[2] <= cfg_data;
                REG_NRM_X:  nrm_reg[0] <= cfg_data;
                REG_NRM_Y:  nrm_reg[1] <= cfg_data;
                REG_NRM_Z:  nrm_reg[2] <= cfg_data;
                REG_MARGIN: margin_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign en      = !e_valid_reg || (m_ready && (!e_split_reg || e_phase_reg));
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[PIPE_LAT-2:0], s_valid};
        end
    end

    always_comb begin
        in_next.ftype     = s_fragment_type;
        in_next.pts[0][0] = s_a_x;
        in_next.pts[0][1] = s_a_y;
        in_next.pts[0][2] = s_a_z;
        in_next.pts[1][0] = s_b_x;
        in_next.pts[1][1] = s_b_y;
        in_next.pts[1][2] = s_b_z;
        in_next.pts[2][0] = s_c_x;
        in_next.pts[2][1] = s_c_y;
        in_next.pts[2][2] = s_c_z;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            in_reg    <= in_next;
            sa_reg[0] <= in_reg;
            for (int i = 1; i < DIST_LAT; i++) begin
                sa_reg[i] <= sa_reg[i-1];
            end
        end
    end

    for (genvar g = 0; g < 3; g++) begin : g_dist
        cfp_dist u_dist (
            .aclk     (aclk),
            .en       (en),
            .pt       (in_reg.pts[g]),
            .plane_pt (ppt_reg),
            .nrm      (nrm_reg),
            .margin   (margin_reg),
            .s        (s_w[g]),
            .bad      (bad_w[g])
        );
    end

    // clip decision: which edges get an intercept and where results come from
    always_comb begin
        frag_t      cur;
        logic [1:0] g, u, w, nbad;
        cur  = sa_reg[DIST_LAT-1];
        nbad = 2'(bad_w[0]) + 2'(bad_w[1]) + 2'(bad_w[2]);
        g = 2'd0;
        u = 2'd1;
        w = 2'd2;
        side_next.ftype = cur.ftype;
        side_next.split = 1'b0;
        side_next.sel0  = {SRC_C, SRC_B, SRC_A};
        side_next.sel1  = {SRC_C, SRC_B, SRC_A};
        side_next.pts   = cur.pts;
        slot_next[0] = '{p: cur.pts[0], q: cur.pts[1], sp: s_w[0], sq: s_w[1]};
        slot_next[1] = slot_next[0];
        case (cur.ftype)
            TYPE_PATH: begin
                if (bad_w[0]) side_next.ftype = TYPE_NONE;
            end
            TYPE_LINE: begin
                if (bad_w[0] && bad_w[1]) begin
                    side_next.ftype = TYPE_NONE;
                end else if (bad_w[0]) begin
                    side_next.sel0[0] = SRC_I0;
                end else if (bad_w[1]) begin
                    side_next.sel0[1] = SRC_I0;
                end
            end
            TYPE_TRI: begin
                case (nbad)
                    2'd3: side_next.ftype = TYPE_NONE;
                    2'd2: begin
                        g = !bad_w[0] ? 2'd0 : !bad_w[1] ? 2'd1 : 2'd2;
                        u = nxt3(g);
                        w = nxt3(u);
                        slot_next[0] = '{p: cur.pts[g], q: cur.pts[u], sp: s_w[g], sq: s_w[u]};
                        slot_next[1] = '{p: cur.pts[g], q: cur.pts[w], sp: s_w[g], sq: s_w[w]};
                        side_next.sel0[u] = SRC_I0;
                        side_next.sel0[w] = SRC_I1;
                    end
                    2'd1: begin
                        g = bad_w[0] ? 2'd0 : bad_w[1] ? 2'd1 : 2'd2;
                        u = nxt3(g);
                        w = nxt3(u);
                        slot_next[0] = '{p: cur.pts[g], q: cur.pts[u], sp: s_w[g], sq: s_w[u]};
                        slot_next[1] = '{p: cur.pts[g], q: cur.pts[w], sp: s_w[g], sq: s_w[w]};
                        side_next.split = 1'b1;
                        side_next.sel0  = {pt_src(u), SRC_I1, pt_src(w)};
                        side_next.sel1  = {SRC_I1, SRC_I0, pt_src(u)};
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sb_reg[0]   <= side_next;
            slot_reg[0] <= slot_next[0];
            slot_reg[1] <= slot_next[1];
            for (int i = 1; i < SB_LEN; i++) begin
                sb_reg[i] <= sb_reg[i-1];
            end
        end
    end

    for (genvar gs = 0; gs < 2; gs++) begin : g_slot
        cfp_isect u_isect (
            .aclk (aclk),
            .en   (en),
            .slot (slot_reg[gs]),
            .an   (an_w[gs]),
            .ad   (ad_w[gs]),
            .neg  (neg_w[gs])
        );
        for (genvar gk = 0; gk < 3; gk++) begin : g_coord
            cfp_div u_div (
                .aclk (aclk),
                .en   (en),
                .num  (an_w[gs][gk]),
                .den  (ad_w[gs]),
                .neg  (neg_w[gs][gk]),
                .res  (ires[gs][gk])
            );
        end
    end

    function automatic vtx_t pick(src_t sel, tri_t pts, vtx_t i0, vtx_t i1);
        vtx_t r;
        case (sel)
            SRC_A:  r = pts[0];
            SRC_B:  r = pts[1];
            SRC_C:  r = pts[2];
            SRC_I0: r = i0;
            SRC_I1: r = i1;
            default: r = pts[0];
        endcase
        return r;
    endfunction

    assign sb_out = sb_reg[SB_LEN-1];

    always_comb begin
        for (int p = 0; p < 3; p++) begin
            r0_next[p] = pick(sb_out.sel0[p], sb_out.pts, ires[0], ires[1]);
            r1_next[p] = pick(sb_out.sel1[p], sb_out.pts, ires[0], ires[1]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_valid_reg <= 1'b0;
            e_phase_reg <= 1'b0;
        end else if (en) begin
            e_valid_reg <= v_reg[PIPE_LAT-1];
            e_phase_reg <= 1'b0;
        end else if (m_ready) begin
            e_phase_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            e_type_reg  <= sb_out.ftype;
            e_split_reg <= sb_out.split;
            e_r0_reg    <= r0_next;
            e_r1_reg    <= r1_next;
        end
    end

    assign cur_tri       = e_phase_reg ? e_r1_reg : e_r0_reg;
    assign m_valid       = e_valid_reg;
    assign m_out_type    = e_type_reg;
    assign m_last_of_run = !e_split_reg || e_phase_reg;
    assign m_out_a_x     = cur_tri[0][0];
    assign m_out_a_y     = cur_tri[0][1];
    assign m_out_a_z     = cur_tri[0][2];
    assign m_out_b_x     = cur_tri[1][0];
    assign m_out_b_y     = cur_tri[1][1];
    assign m_out_b_z     = cur_tri[1][2];
    assign m_out_c_x     = cur_tri[2][0];
    assign m_out_c_y     = cur_tri[2][1];
    assign m_out_c_z     = cur_tri[2][2];

endmodule

[rtl/core/cfp_checker.sv]
module cfp_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [2:0] m_out_type,
    input logic       m_last_of_run
);
    import cfp_pkg::*;

    // stalled result stays up
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    // only a split triangle has a non-final result
    a_split_type: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last_of_run |-> m_out_type == TYPE_TRI)
        else $error("non-final result is not a triangle");

    // second half of a split follows right away
    a_split_next: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_of_run |=> m_valid && m_last_of_run
            && m_out_type == TYPE_TRI)
        else $error("split triangle missing its second result");

    // input is held while the first half of a split is pending
    a_split_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last_of_run |-> !s_ready)
        else $error("input taken during split output");

endmodule

bind clip_fragment_against_plane cfp_checker u_cfp_checker (.*);
